// ===== hw/rtl/ptd_pkg.sv =====
package ptd_pkg;

   // input actions
   localparam logic [1:0] ACT_CREATE   = 2'd0;
   localparam logic [1:0] ACT_DELETE   = 2'd1;
   localparam logic [1:0] ACT_OVERFLOW = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] period;
      logic [7:0]  priority_val;
      logic [15:0] counter;
      logic        ready;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       idx_clr;
      logic       idx_inc;
      logic       insert;
      logic       remove;
      logic       tick_step;
      logic       ovf_bump;
      logic       status_we;
      logic [1:0] status;
      logic       load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] act;
      logic       id_null;
      logic       full;
      logic       empty;
      logic       tick_hit;
      logic       scan_end;
      logic       pri_gt;
      logic       id_match;
      logic       out_busy;
   } stat_type;

endpackage

// ===== hw/rtl/ptd_ctrl.sv =====
module ptd_ctrl
   import ptd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_CSCAN  = 3'd2;
   localparam logic [2:0] S_INSERT = 3'd3;
   localparam logic [2:0] S_DSCAN  = 3'd4;
   localparam logic [2:0] S_REMOVE = 3'd5;
   localparam logic [2:0] S_TWALK  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.idx_clr  = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.act)
               ACT_CREATE: begin
                  if (stat.id_null) begin
                     cmd.status_we = 1'b1;
                     cmd.status    = ST_NULL;
                     state_in      = S_DONE;
                  end else if (stat.full) begin
                     cmd.status_we = 1'b1;
                     cmd.status    = ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_CSCAN;
                  end
               end
               ACT_DELETE: begin
                  // empty table is reported ahead of a null id
                  if (stat.empty) begin
                     cmd.status_we = 1'b1;
                     cmd.status    = ST_EMPTY;
                     state_in      = S_DONE;
                  end else if (stat.id_null) begin
                     cmd.status_we = 1'b1;
                     cmd.status    = ST_NULL;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_DSCAN;
                  end
               end
               ACT_OVERFLOW: begin
                  cmd.ovf_bump = 1'b1;
                  state_in     = stat.tick_hit ? S_TWALK : S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_CSCAN: begin
            // insert after every entry of equal or lower priority value
            if (stat.scan_end || stat.pri_gt) begin
               state_in = S_INSERT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_DONE;
         end
         S_DSCAN: begin
            if (stat.scan_end) begin
               state_in = S_DONE;
            end else if (stat.id_match) begin
               state_in = S_REMOVE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_REMOVE: begin
            cmd.remove = 1'b1;
            state_in   = S_DONE;
         end
         S_TWALK: begin
            if (stat.scan_end) begin
               state_in = S_DONE;
            end else begin
               cmd.tick_step = 1'b1;
               cmd.idx_inc   = 1'b1;
            end
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/ptd_dp.sv =====
module ptd_dp
   import ptd_pkg::*;
#(
   parameter int TASKS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_task_id,
   input  logic [15:0] req_period,
   input  logic [7:0]  req_priority_req,
   input  logic        req_start_ready,
   input  logic        csr_valid,
   input  logic [7:0]  csr_tick_divide,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_dispatch_valid,
   output logic [7:0]  rsp_dispatch_task,
   output logic [3:0]  rsp_task_count
);

   localparam int CW = $clog2(TASKS + 1);
   localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;

   entry_type ent_ff [TASKS];
   entry_type ent_in [TASKS];

   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [7:0]    ovf_ff, ovf_in;
   logic [7:0]    tdiv_ff, tdiv_in;
   logic          found_ff, found_in;
   logic [7:0]    who_ff, who_in;
   logic [1:0]    status_ff, status_in;

   logic [1:0]    act_ff;
   logic [7:0]    id_ff;
   logic [15:0]   per_ff;
   logic [7:0]    pri_ff;
   logic          srdy_ff;

   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_status_ff;
   logic          out_disp_ff;
   logic [7:0]    out_who_ff;
   logic [3:0]    out_count_ff;

   logic [IW-1:0] ix;
   entry_type     rd;
   entry_type     new_ent;
   logic [7:0]    ovf_next;
   logic [15:0]   cnt_next;
   logic          rdy_next;
   logic [CW+3:0] total_ext;

   assign ix       = idx_ff[IW-1:0];
   assign rd       = (idx_ff < CW'(TASKS)) ? ent_ff[ix] : '0;
   assign ovf_next = ovf_ff + 8'd1;

   // saturating tick count of the walked entry
   assign cnt_next = (rd.counter == 16'hFFFF) ? rd.counter : rd.counter + 16'd1;
   assign rdy_next = rd.ready | (cnt_next >= rd.period);

   always_comb begin
      new_ent              = '0;
      new_ent.id           = id_ff;
      new_ent.period       = per_ff;
      new_ent.priority_val = pri_ff;
      new_ent.ready        = srdy_ff;
   end

   assign stat.act      = act_ff;
   assign stat.id_null  = (id_ff == 8'd0);
   assign stat.full     = (total_ff >= CW'(TASKS));
   assign stat.empty    = (total_ff == '0);
   assign stat.tick_hit = (ovf_next == tdiv_ff);
   assign stat.scan_end = (idx_ff == total_ff);
   assign stat.pri_gt   = (rd.priority_val > pri_ff);
   assign stat.id_match = (rd.id == id_ff);
   assign stat.out_busy = out_valid_ff & ~rsp_ready;

   always_comb begin
      for (int j = 0; j < TASKS; j++) begin
         ent_in[j] = ent_ff[j];
         if (cmd.insert) begin
            if (CW'(j) == idx_ff) begin
               ent_in[j] = new_ent;
            end else if (CW'(j) > idx_ff) begin
               ent_in[j] = ent_ff[(j + TASKS - 1) % TASKS];
            end
         end else if (cmd.remove) begin
            // slots past the fill level hold zero, so the gap closes cleanly
            if (CW'(j) >= idx_ff) begin
               ent_in[j] = (j == TASKS - 1) ? '0 : ent_ff[(j+1) % TASKS];
            end
         end else if (cmd.tick_step && (CW'(j) == idx_ff)) begin
            if (rdy_next && !found_ff) begin
               ent_in[j].counter = 16'd0;
               ent_in[j].ready   = 1'b0;
            end else begin
               ent_in[j].counter = cnt_next;
               ent_in[j].ready   = rdy_next;
            end
         end
      end
   end

   always_comb begin
      total_in  = total_ff;
      idx_in    = idx_ff;
      ovf_in    = ovf_ff;
      tdiv_in   = tdiv_ff;
      found_in  = found_ff;
      who_in    = who_ff;
      status_in = status_ff;

      if (cmd.insert) begin
         total_in = total_ff + CW'(1);
      end else if (cmd.remove) begin
         total_in = total_ff - CW'(1);
      end

      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end

      if (cmd.ovf_bump) begin
         ovf_in = stat.tick_hit ? 8'd0 : ovf_next;
      end

      if (csr_valid) begin
         tdiv_in = csr_tick_divide;
      end

      if (cmd.load_req) begin
         found_in  = 1'b0;
         who_in    = 8'd0;
         status_in = ST_OK;
      end else begin
         if (cmd.tick_step && rdy_next && !found_ff) begin
            found_in = 1'b1;
            who_in   = rd.id;
         end
         if (cmd.status_we) begin
            status_in = cmd.status;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign total_ext = {4'b0000, total_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TASKS; j++) begin
            ent_ff[j] <= '0;
         end
         total_ff     <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 8'd0;
         tdiv_ff      <= 8'd1;
         found_ff     <= 1'b0;
         who_ff       <= 8'd0;
         status_ff    <= ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         for (int j = 0; j < TASKS; j++) begin
            ent_ff[j] <= ent_in[j];
         end
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         tdiv_ff      <= tdiv_in;
         found_ff     <= found_in;
         who_ff       <= who_in;
         status_ff    <= status_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff  <= req_action;
         id_ff   <= req_task_id;
         per_ff  <= req_period;
         pri_ff  <= req_priority_req;
         srdy_ff <= req_start_ready;
      end
      if (cmd.load_out) begin
         out_status_ff <= status_ff;
         out_disp_ff   <= found_ff;
         out_who_ff    <= who_ff;
         out_count_ff  <= total_ext[3:0];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_dispatch_valid = out_disp_ff;
   assign rsp_dispatch_task  = out_who_ff;
   assign rsp_task_count     = out_count_ff;

endmodule

// ===== hw/rtl/periodic_task_dispatcher.sv =====
// channel   valid      ready      payload
// req       req_valid  req_ready  req_action, req_task_id, req_period,
//                                 req_priority_req, req_start_ready
// rsp       rsp_valid  rsp_ready  rsp_status, rsp_dispatch_valid,
//                                 rsp_dispatch_task, rsp_task_count
// csr       csr_valid  csr_ready  csr_tick_divide
//
// one beat at a time: a rejected or plain beat needs no walk; create, delete
// or a scheduler tick walks over the task table
// at one entry per cycle in the datapath
// synchronous reset empties the table, clears the divider, tick_divide = 1
// a finished result sits in the output register; the next req beat is taken
// meanwhile and its result waits until the held one is taken
module periodic_task_dispatcher
   import ptd_pkg::*;
#(
   parameter int TASKS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_task_id,
   input  logic [15:0] req_period,
   input  logic [7:0]  req_priority_req,
   input  logic        req_start_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_dispatch_valid,
   output logic [7:0]  rsp_dispatch_task,
   output logic [3:0]  rsp_task_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_tick_divide
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   ptd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptd_dp #(
      .TASKS (TASKS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_action         (req_action),
      .req_task_id        (req_task_id),
      .req_period         (req_period),
      .req_priority_req   (req_priority_req),
      .req_start_ready    (req_start_ready),
      .csr_valid          (csr_valid),
      .csr_tick_divide    (csr_tick_divide),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_dispatch_valid (rsp_dispatch_valid),
      .rsp_dispatch_task  (rsp_dispatch_task),
      .rsp_task_count     (rsp_task_count)
   );

endmodule
